// ===== design/sha256_stream_hasher_defines.svh =====
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned RamDepth   = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenStart   = 6'd56;

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic       init;
    logic       load_en;
    byte_sel_e  sel;
    logic [5:0] load_idx;
    logic       rnd_start;
    logic       rnd_en;
    logic [5:0] rnd_idx;
    logic       fold;
    logic       add_bits;
    logic [5:0] len_bytes;
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [5:0] rd_addr;
  } ctrl_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage

// ===== design/sha_ram.sv =====
`timescale 1ns / 1ps
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/sha_datapath.sv =====
`timescale 1ns / 1ps
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::ctrl_t    ctrl_i,
  input  logic [2:0]        out_idx_i,
  output logic [31:0]       digest_word_o
);
  import sha_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [63:0] bits_q;
  logic [7:0]  ram_rdata;
  logic [7:0]  lbyte;
  logic [63:0] total;
  logic [31:0] wt, s0, s1, t1, t2, ch, mj, bs0, bs1;

  sha_ram #(.Width(8), .Depth(RamDepth)) u_buf (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .waddr_i(ctrl_i.wr_addr),
    .wdata_i(ctrl_i.wr_data),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ctrl_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  assign total = bits_q + {55'd0, ctrl_i.len_bytes, 3'd0};

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_DATA: lbyte = ram_rdata;
      SEL_PAD:  lbyte = PadByte;
      SEL_ZERO: lbyte = 8'd0;
      SEL_LEN:  lbyte = total[8*(7-ctrl_i.load_idx[2:0]) +: 8];
      default:  lbyte = 8'd0;
    endcase
  end

  always_comb begin
    s0  = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1  = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wt  = w_q[0];
    bs1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + bs1 + ch + RoundK[ctrl_i.rnd_idx] + wt;
    bs0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = bs0 + mj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      bits_q <= '0;
    end else if (ctrl_i.init) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      bits_q <= '0;
    end else begin
      if (ctrl_i.fold) for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      if (ctrl_i.add_bits) bits_q <= bits_q + 64'd512;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en) begin
      w_q[ctrl_i.load_idx[5:2]] <= {w_q[ctrl_i.load_idx[5:2]][23:0], lbyte};
    end else if (ctrl_i.rnd_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
    end
    if (ctrl_i.rnd_start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (ctrl_i.rnd_en) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  assign digest_word_o = h_q[out_idx_i];
endmodule

// ===== design/sha_ctrl.sv =====
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
module sha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           action_i,
  input  logic [7:0]     data_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     out_idx_o,
  output sha_pkg::ctrl_t ctrl_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] pend_q, pend_d;
  logic [6:0] cnt_q, cnt_d;
  logic       fin_q, fin_d;
  logic       extra_q, extra_d;
  logic       second_q, second_d;
  logic [2:0] oidx_q, oidx_d;
  logic       in_acc;
  logic [5:0] bi;
  logic       rd_valid;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_idx_o   = oidx_q;

  // read in LOAD leads its use through the RAM read register: cnt 0..63 reads, cnt 1..64 loads
  assign bi       = cnt_q[5:0] - 6'd1;
  assign rd_valid = !second_q && (bi < pend_q);

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    extra_d  = extra_q;
    second_d = second_q;
    oidx_d   = oidx_q;
    ctrl_o   = '0;
    ctrl_o.sel       = SEL_ZERO;
    ctrl_o.len_bytes = pend_q;
    ctrl_o.wr_addr   = pend_q;
    ctrl_o.wr_data   = data_byte_i;
    ctrl_o.rd_addr   = cnt_q[5:0];
    ctrl_o.load_idx  = bi;
    ctrl_o.rnd_idx   = cnt_q[5:0];
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d    = '0;
          second_d = 1'b0;
          if (!action_i) begin
            ctrl_o.wr_en = 1'b1;
            pend_d = pend_q + 6'd1;
            if (pend_q == 6'd63) begin
              fin_d   = 1'b0;
              state_d = ST_LOAD;
            end
          end else begin
            fin_d   = 1'b1;
            extra_d = (pend_q >= LenStart);
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        ctrl_o.rd_en = (cnt_q < 7'd64);
        if (cnt_q != 7'd0) begin
          ctrl_o.load_en = 1'b1;
          if (!fin_q) ctrl_o.sel = SEL_DATA;
          else if (rd_valid) ctrl_o.sel = SEL_DATA;
          else if (!second_q && bi == pend_q) ctrl_o.sel = SEL_PAD;
          else if (!extra_q && bi >= LenStart) ctrl_o.sel = SEL_LEN;
          else if (second_q && bi >= LenStart) ctrl_o.sel = SEL_LEN;
          else ctrl_o.sel = SEL_ZERO;
        end
        if (cnt_q == 7'd64) begin
          ctrl_o.rnd_start = 1'b1;
          cnt_d   = '0;
          state_d = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_ROUND: begin
        ctrl_o.rnd_en = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl_o.fold = 1'b1;
        cnt_d = '0;
        if (!fin_q) begin
          ctrl_o.add_bits = 1'b1;
          state_d = ST_IDLE;
        end else if (extra_q && !second_q) begin
          second_d = 1'b1;
          state_d  = ST_LOAD;
        end else begin
          oidx_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ctrl_o.init = 1'b1;
            pend_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= '0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      extra_q  <= 1'b0;
      second_q <= 1'b0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      extra_q  <= extra_d;
      second_q <= second_d;
      oidx_q   <= oidx_d;
    end
  end

  `SHA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `SHA_ASSERT_NEXT(a_round_cnt, clk_i, rst_ni, state_q == ST_ROUND && cnt_q == 7'd63,
                   state_q == ST_FOLD)
  `SHA_ASSERT_IMP(a_second_fin, clk_i, rst_ni, second_q, fin_q && extra_q)
  `SHA_ASSERT_NEXT(a_emit_wrap, clk_i, rst_ni,
                   out_valid_o && out_ready_i && oidx_q == 3'd7,
                   state_q == ST_IDLE && pend_q == 6'd0)
endmodule

// ===== design/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// SHA-256 stream hasher.
// Input channel (in_valid_i/in_ready_o): one byte per item, action_i = 0
// absorbs data_byte_i, action_i = 1 closes the message and pads it.
// Output channel (out_valid_o/out_ready_i): after a finish, eight digest
// words, word_index_o 0 to 7, last_word_o high on the eighth.
// The 64th byte of a block starts a compression: a load of the block from
// the buffer, 64 rounds through one shared round unit and a fold; no
// further byte is taken until the compression is done.
// A finish takes one compression, or two when 56 or more bytes are pending,
// then the digest words follow one a cycle while the receiver takes them.
// The block buffer is a 64-byte RAM with registered read.
// A stalled receiver holds the current digest word; no input is taken
// until all eight words are delivered, after which the state reinitializes.
// Reset loads the initial hash words and clears byte and bit counts; the
// block is ready straight out of reset.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  ctrl_t      ctrl;
  logic [2:0] oidx;

  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_idx_o  (oidx),
    .ctrl_o     (ctrl)
  );

  sha_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .out_idx_i    (oidx),
    .digest_word_o(digest_word_o)
  );

  assign word_index_o = oidx;
  assign last_word_o  = (oidx == 3'd7);
endmodule
